// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/mstk_pkg.sv -----
package mstk_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int VERT_BITS    = 5;
  localparam int VC_BITS      = 6;
  localparam int W_BITS       = 16;
  localparam int SUM_BITS     = 21;
  localparam int RANK_BITS    = 3;
  localparam int RANK_MAX     = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN_START,
    ST_SCAN,
    ST_TAKE,
    ST_FIND_A,
    ST_COMP_A,
    ST_SETUP_B,
    ST_FIND_B,
    ST_COMP_B,
    ST_JOIN,
    ST_PUSH,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_SCAN_START,
    OP_SCAN,
    OP_TAKE,
    OP_FIND,
    OP_COMP,
    OP_SETUP_B,
    OP_JOIN,
    OP_PUSH,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic busy;
  } cmd_t;

  typedef struct packed {
    logic final_in;
    logic stored_zero;
    logic scan_done;
    logic have_best;
    logic root_hit;
    logic same_set;
    logic push_done;
    logic tree_done;
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/mstk_ctrl.sv -----
module mstk_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  mstk_pkg::sts_t  sts,
  output mstk_pkg::cmd_t  cmd
);

  mstk_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mstk_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = mstk_pkg::OP_NONE;
    cmd.busy   = 1'b1;
    unique case (state)
      mstk_pkg::ST_IDLE: begin
        cmd.busy = 1'b0;
        if (sts.final_in) state_next = mstk_pkg::ST_INIT;
      end
      mstk_pkg::ST_INIT: begin
        cmd.op     = mstk_pkg::OP_INIT;
        state_next = sts.stored_zero ? mstk_pkg::ST_FINISH : mstk_pkg::ST_SCAN_START;
      end
      mstk_pkg::ST_SCAN_START: begin
        cmd.op     = mstk_pkg::OP_SCAN_START;
        state_next = mstk_pkg::ST_SCAN;
      end
      mstk_pkg::ST_SCAN: begin
        cmd.op = mstk_pkg::OP_SCAN;
        if (sts.scan_done) begin
          state_next = sts.have_best ? mstk_pkg::ST_TAKE : mstk_pkg::ST_FINISH;
        end
      end
      mstk_pkg::ST_TAKE: begin
        cmd.op     = mstk_pkg::OP_TAKE;
        state_next = mstk_pkg::ST_FIND_A;
      end
      mstk_pkg::ST_FIND_A: begin
        cmd.op = mstk_pkg::OP_FIND;
        if (sts.root_hit) state_next = mstk_pkg::ST_COMP_A;
      end
      mstk_pkg::ST_COMP_A: begin
        cmd.op = mstk_pkg::OP_COMP;
        if (sts.root_hit) state_next = mstk_pkg::ST_SETUP_B;
      end
      mstk_pkg::ST_SETUP_B: begin
        cmd.op     = mstk_pkg::OP_SETUP_B;
        state_next = mstk_pkg::ST_FIND_B;
      end
      mstk_pkg::ST_FIND_B: begin
        cmd.op = mstk_pkg::OP_FIND;
        if (sts.root_hit) state_next = mstk_pkg::ST_COMP_B;
      end
      mstk_pkg::ST_COMP_B: begin
        cmd.op = mstk_pkg::OP_COMP;
        if (sts.root_hit) state_next = mstk_pkg::ST_JOIN;
      end
      mstk_pkg::ST_JOIN: begin
        cmd.op     = mstk_pkg::OP_JOIN;
        state_next = sts.same_set ? mstk_pkg::ST_SCAN_START : mstk_pkg::ST_PUSH;
      end
      mstk_pkg::ST_PUSH: begin
        cmd.op = mstk_pkg::OP_PUSH;
        if (sts.push_done) begin
          state_next = sts.tree_done ? mstk_pkg::ST_FINISH : mstk_pkg::ST_SCAN_START;
        end
      end
      mstk_pkg::ST_FINISH: begin
        cmd.op = mstk_pkg::OP_FINISH;
        if (sts.out_free) state_next = mstk_pkg::ST_IDLE;
      end
      default: begin
        state_next = mstk_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/mstk_dp.sv -----
module mstk_dp #(
  parameter int MAX_EDGES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [5:0]           cfg_wdata,
  input  logic                 in_valid,
  input  logic [4:0]           from_vertex,
  input  logic [4:0]           to_vertex,
  input  logic signed [15:0]   edge_weight,
  input  logic                 final_edge,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 edge_valid,
  output logic [4:0]           tree_from,
  output logic [4:0]           tree_to,
  output logic signed [15:0]   tree_weight,
  output logic signed [20:0]   running_total,
  output logic [4:0]           tree_edges,
  output logic                 tree_complete,
  output logic                 last_result,
  input  mstk_pkg::cmd_t       cmd,
  output mstk_pkg::sts_t       sts
);

  localparam int VB = mstk_pkg::VERT_BITS;
  localparam int WB = mstk_pkg::W_BITS;
  localparam int SB = mstk_pkg::SUM_BITS;
  localparam int RB = mstk_pkg::RANK_BITS;
  localparam int NV = mstk_pkg::MAX_VERTICES;
  localparam int IW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int EW = 2 * VB + WB;
  localparam int KW = WB + IW;

  // configuration
  logic [mstk_pkg::VC_BITS-1:0] vertex_count;
  logic [mstk_pkg::VC_BITS-1:0] nv;
  logic [VB-1:0]                target;

  // edge store
  logic [EW-1:0] mem [MAX_EDGES];
  logic [EW-1:0] mem_q;
  logic [CW-1:0] stored;
  logic          load;
  logic          store_ok;

  // selection scan
  logic [CW-1:0] k;
  logic [IW-1:0] rd_idx;
  logic          rd_v;
  logic          have_prev;
  logic [KW-1:0] prev_key;
  logic          have_best;
  logic [KW-1:0] best_key;
  logic [VB-1:0] best_a;
  logic [VB-1:0] best_b;
  logic [WB-1:0] best_w;
  logic [VB-1:0] q_a;
  logic [VB-1:0] q_b;
  logic [WB-1:0] q_w;
  logic [KW-1:0] q_key;
  logic          cand;

  // union-find
  logic [VB-1:0] parent [NV];
  logic [RB-1:0] rank_r [NV];
  logic [VB-1:0] ptr;
  logic [VB-1:0] start;
  logic [VB-1:0] root;
  logic [RB-1:0] root_rank;
  logic [VB-1:0] ra;
  logic [RB-1:0] ra_rank;
  logic [VB-1:0] par_ptr;
  logic          root_hit;

  // totals and pending result
  logic signed [SB-1:0] sum;
  logic [VB-1:0]        cnt;
  logic                 pend_v;
  logic [VB-1:0]        pend_a;
  logic [VB-1:0]        pend_b;
  logic [WB-1:0]        pend_w;
  logic signed [SB-1:0] pend_sum;
  logic [VB-1:0]        pend_cnt;
  logic                 out_free;
  logic                 load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= mstk_pkg::VC_BITS'(NV);
    end else if (cfg_write) begin
      vertex_count <= cfg_wdata;
    end
  end

  always_comb begin
    if (vertex_count == '0) begin
      nv = mstk_pkg::VC_BITS'(1);
    end else if (vertex_count > mstk_pkg::VC_BITS'(NV)) begin
      nv = mstk_pkg::VC_BITS'(NV);
    end else begin
      nv = vertex_count;
    end
  end

  assign target   = VB'(nv - mstk_pkg::VC_BITS'(1));
  assign load     = in_valid && !cmd.busy;
  assign store_ok = (stored < CW'(MAX_EDGES)) && ({1'b0, from_vertex} < nv) &&
                    ({1'b0, to_vertex} < nv);

  always_ff @(posedge clk) begin
    if (rst) begin
      stored <= '0;
    end else if (cmd.op == mstk_pkg::OP_FINISH && out_free) begin
      stored <= '0;
    end else if (load && store_ok) begin
      stored <= stored + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load && store_ok) mem[stored[IW-1:0]] <= {from_vertex, to_vertex, edge_weight};
  end

  always_ff @(posedge clk) begin
    if (cmd.op == mstk_pkg::OP_SCAN && k < stored) mem_q <= mem[k[IW-1:0]];
  end

  // order key: weight with sign flipped, then load index for stability
  assign q_a   = mem_q[EW-1 -: VB];
  assign q_b   = mem_q[WB +: VB];
  assign q_w   = mem_q[WB-1:0];
  assign q_key = {~q_w[WB-1], q_w[WB-2:0], rd_idx};
  assign cand  = rd_v && ({1'b0, q_a} < nv) && ({1'b0, q_b} < nv) &&
                 (!have_prev || q_key > prev_key) && (!have_best || q_key < best_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v      <= 1'b0;
      have_prev <= 1'b0;
      have_best <= 1'b0;
      k         <= '0;
    end else begin
      unique case (cmd.op)
        mstk_pkg::OP_INIT: begin
          have_prev <= 1'b0;
        end
        mstk_pkg::OP_SCAN_START: begin
          k         <= '0;
          rd_v      <= 1'b0;
          have_best <= 1'b0;
        end
        mstk_pkg::OP_SCAN: begin
          if (k < stored) begin
            rd_idx <= k[IW-1:0];
            rd_v   <= 1'b1;
            k      <= k + CW'(1);
          end else begin
            rd_v <= 1'b0;
          end
          if (cand) begin
            have_best <= 1'b1;
            best_key  <= q_key;
            best_a    <= q_a;
            best_b    <= q_b;
            best_w    <= q_w;
          end
        end
        mstk_pkg::OP_TAKE: begin
          have_prev <= 1'b1;
          prev_key  <= best_key;
        end
        default: begin
        end
      endcase
    end
  end

  assign par_ptr  = parent[ptr];
  assign root_hit = (par_ptr == ptr);

  always_ff @(posedge clk) begin
    if (rst || cmd.op == mstk_pkg::OP_INIT) begin
      for (int i = 0; i < NV; i++) begin
        parent[i] <= VB'(i);
        rank_r[i] <= '0;
      end
    end else begin
      unique case (cmd.op)
        mstk_pkg::OP_COMP: begin
          if (!root_hit) parent[ptr] <= root;
        end
        mstk_pkg::OP_JOIN: begin
          if (ra != root) begin
            if (ra_rank < root_rank) begin
              parent[ra] <= root;
            end else begin
              parent[root] <= ra;
              if (ra_rank == root_rank && ra_rank < RB'(mstk_pkg::RANK_MAX)) begin
                rank_r[ra] <= ra_rank + RB'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      mstk_pkg::OP_TAKE: begin
        ptr   <= best_a;
        start <= best_a;
      end
      mstk_pkg::OP_FIND: begin
        if (root_hit) begin
          root      <= ptr;
          root_rank <= rank_r[ptr];
          ptr       <= start;
        end else begin
          ptr <= par_ptr;
        end
      end
      mstk_pkg::OP_COMP: begin
        if (!root_hit) ptr <= par_ptr;
      end
      mstk_pkg::OP_SETUP_B: begin
        ra      <= root;
        ra_rank <= root_rank;
        ptr     <= best_b;
        start   <= best_b;
      end
      default: begin
      end
    endcase
  end

  assign out_free = !out_valid || !out_stall;
  assign load_out = out_free && ((cmd.op == mstk_pkg::OP_PUSH && pend_v) ||
                                 cmd.op == mstk_pkg::OP_FINISH);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum    <= '0;
      cnt    <= '0;
      pend_v <= 1'b0;
    end else begin
      unique case (cmd.op)
        mstk_pkg::OP_INIT: begin
          sum    <= '0;
          cnt    <= '0;
          pend_v <= 1'b0;
        end
        mstk_pkg::OP_JOIN: begin
          if (ra != root) begin
            sum <= sum + {{(SB-WB){best_w[WB-1]}}, best_w};
            cnt <= cnt + VB'(1);
          end
        end
        mstk_pkg::OP_PUSH: begin
          if (!pend_v || out_free) begin
            pend_v   <= 1'b1;
            pend_a   <= best_a;
            pend_b   <= best_b;
            pend_w   <= best_w;
            pend_sum <= sum;
            pend_cnt <= cnt;
          end
        end
        mstk_pkg::OP_FINISH: begin
          if (out_free) pend_v <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (pend_v) begin
        edge_valid    <= 1'b1;
        tree_from     <= pend_a;
        tree_to       <= pend_b;
        tree_weight   <= pend_w;
        running_total <= pend_sum;
        tree_edges    <= pend_cnt;
      end else begin
        edge_valid    <= 1'b0;
        tree_from     <= '0;
        tree_to       <= '0;
        tree_weight   <= '0;
        running_total <= '0;
        tree_edges    <= '0;
      end
      last_result   <= (cmd.op == mstk_pkg::OP_FINISH);
      tree_complete <= (cmd.op == mstk_pkg::OP_FINISH) &&
                       (pend_v ? (pend_cnt == target) : (target == '0));
    end
  end

  always_comb begin
    sts.final_in    = in_valid && final_edge;
    sts.stored_zero = (stored == '0);
    sts.scan_done   = (k == stored) && !rd_v;
    sts.have_best   = have_best;
    sts.root_hit    = root_hit;
    sts.same_set    = (ra == root);
    sts.push_done   = !pend_v || out_free;
    sts.tree_done   = (cnt == target);
    sts.out_free    = out_free;
  end

endmodule

// ----- hdl/minimum_spanning_tree_kruskal_core.sv -----
// Edge requests load only while the controller is idle; the request marked final starts a run.
// Run: init, then per edge taken one scan of the store, a root walk and a compress pass
//   per endpoint, join and, for a new tree edge, push; the run closes when the tree is
//   complete or a scan finds nothing, with output stalls holding push and finish.
// Throughput: one graph at a time; input stalls from the final request to the last result.
// Reset (rst, synchronous): store empty, sets cleared, vertex_count = 32, no result pending.
`include "assert_macros.svh"

module minimum_spanning_tree_kruskal_core #(
  parameter int MAX_EDGES = 256
) (
  input  logic                clk,
  input  logic                rst,
  // configuration: vertex count
  input  logic                cfg_write,
  input  logic [5:0]          cfg_wdata,
  // edge requests
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [4:0]          from_vertex,
  input  logic [4:0]          to_vertex,
  input  logic signed [15:0]  edge_weight,
  input  logic                final_edge,
  // tree results
  output logic                out_valid,
  input  logic                out_stall,
  output logic                edge_valid,
  output logic [4:0]          tree_from,
  output logic [4:0]          tree_to,
  output logic signed [15:0]  tree_weight,
  output logic signed [20:0]  running_total,
  output logic [4:0]          tree_edges,
  output logic                tree_complete,
  output logic                last_result
);

  // Controller sequences: init sets, scan for next-smallest edge by (weight, load
  // order), walk both roots with compression, join by rank, then hand the
  // accepted edge to a one-deep pending stage so the final one can carry the
  // last/complete flags.
  mstk_pkg::cmd_t cmd;
  mstk_pkg::sts_t sts;

  mstk_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  mstk_dp #(
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .from_vertex   (from_vertex),
    .to_vertex     (to_vertex),
    .edge_weight   (edge_weight),
    .final_edge    (final_edge),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .edge_valid    (edge_valid),
    .tree_from     (tree_from),
    .tree_to       (tree_to),
    .tree_weight   (tree_weight),
    .running_total (running_total),
    .tree_edges    (tree_edges),
    .tree_complete (tree_complete),
    .last_result   (last_result),
    .cmd           (cmd),
    .sts           (sts)
  );

  // requests are taken only while the controller is idle
  assign in_stall = cmd.busy;

  // an empty result only ever closes a run
  `ASSERT_IMPL(a_empty_is_last, clk, rst, out_valid && !edge_valid, last_result)
  // an empty result carries zero totals
  `ASSERT_IMPL(a_empty_zero, clk, rst, out_valid && !edge_valid,
               tree_edges == 5'd0 && running_total == 21'sd0)
  // complete flag only on the last result
  `ASSERT_IMPL(a_complete_last, clk, rst, out_valid && tree_complete, last_result)
  // a final request always starts a run
  `ASSERT_NEXT(a_final_starts, clk, rst, in_valid && !in_stall && final_edge, in_stall)

endmodule

// ----- verif/mst_checker.sv -----
`timescale 1ns / 100ps

// Watches the edge and tree channels, models the spanning-tree run and
// compares every tree result against the oldest predicted one.
module mst_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [5:0]         cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [4:0]         from_vertex,
  input  logic [4:0]         to_vertex,
  input  logic signed [15:0] edge_weight,
  input  logic               final_edge,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               edge_valid,
  input  logic [4:0]         tree_from,
  input  logic [4:0]         tree_to,
  input  logic signed [15:0] tree_weight,
  input  logic signed [20:0] running_total,
  input  logic [4:0]         tree_edges,
  input  logic               tree_complete,
  input  logic               last_result,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen,
  output int                 graphs_seen
);

  localparam int EDGE_CAP = 256;

  typedef struct packed {
    logic                valid;
    logic [4:0]          a;
    logic [4:0]          b;
    logic signed [15:0]  w;
    logic signed [20:0]  total;
    logic [4:0]          cnt;
    logic                complete;
    logic                last;
  } tree_res_t;

  typedef struct {
    logic [4:0]         a;
    logic [4:0]         b;
    logic signed [15:0] w;
  } edge_t;

  tree_res_t tree_q[$];
  edge_t     edges[EDGE_CAP];
  int        edge_n;
  logic [5:0] vcount;
  logic [4:0] parent[mstk_pkg::MAX_VERTICES];
  logic [2:0] rnk[mstk_pkg::MAX_VERTICES];

  function automatic int num_vertices();
    if (vcount == 0) return 1;
    if (vcount > mstk_pkg::MAX_VERTICES) return mstk_pkg::MAX_VERTICES;
    return vcount;
  endfunction

  function automatic logic [4:0] find_root(logic [4:0] x);
    logic [4:0] r;
    logic [4:0] n;
    logic [4:0] nx;
    r = x;
    while (parent[r] != r) r = parent[r];
    n = x;
    while (parent[n] != n) begin
      nx = parent[n];
      parent[n] = r;
      n = nx;
    end
    return r;
  endfunction

  // Load one edge; on the final mark run Kruskal and queue the tree results.
  task automatic predict_tree(edge_t e, logic fin);
    int nv;
    int taken;
    edge_t key;
    int j;
    logic signed [20:0] sum;
    logic [4:0] ra;
    logic [4:0] rb;
    tree_res_t r;
    nv = num_vertices();
    if (edge_n < EDGE_CAP && e.a < nv && e.b < nv) begin
      edges[edge_n] = e;
      edge_n++;
    end
    if (!fin) return;
    // stable insertion sort by weight
    for (int i = 1; i < edge_n; i++) begin
      key = edges[i];
      j = i;
      while (j > 0 && edges[j-1].w > key.w) begin
        edges[j] = edges[j-1];
        j--;
      end
      edges[j] = key;
    end
    for (int i = 0; i < mstk_pkg::MAX_VERTICES; i++) begin
      parent[i] = 5'(i);
      rnk[i] = 3'd0;
    end
    taken = 0;
    sum = 0;
    for (int i = 0; i < edge_n && taken < nv - 1; i++) begin
      if (edges[i].a >= nv || edges[i].b >= nv) continue;
      ra = find_root(edges[i].a);
      rb = find_root(edges[i].b);
      if (ra == rb) continue;
      if (rnk[ra] < rnk[rb]) parent[ra] = rb;
      else if (rnk[ra] > rnk[rb]) parent[rb] = ra;
      else begin
        parent[rb] = ra;
        if (rnk[ra] < 7) rnk[ra]++;
      end
      sum += edges[i].w;
      taken++;
      r = '{1'b1, edges[i].a, edges[i].b, edges[i].w, sum, taken[4:0], 1'b0, 1'b0};
      tree_q = {tree_q, r};
    end
    if (taken == 0) begin
      r = '0;
      r.last = 1'b1;
      r.complete = (nv == 1);
      tree_q = {tree_q, r};
    end else begin
      tree_q[$].last = 1'b1;
      tree_q[$].complete = (taken == nv - 1);
    end
    edge_n = 0;
    graphs_seen++;
  endtask

  always @(posedge clk) begin
    edge_t e;
    tree_res_t got;
    tree_res_t want;
    if (rst) begin
      vcount = 6'd32;
      edge_n = 0;
      tree_q.delete();
      fail_count <= 0;
      results_seen <= 0;
      graphs_seen = 0;
    end else begin
      if (in_valid && !in_stall) begin
        e = '{from_vertex, to_vertex, edge_weight};
        predict_tree(e, final_edge);
      end
      if (cfg_write) vcount = cfg_wdata;
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        got = '{edge_valid, tree_from, tree_to, tree_weight, running_total, tree_edges,
                tree_complete, last_result};
        if (tree_q.size() == 0) begin
          if (fail_count < 10) $display("ERROR: unexpected tree result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = tree_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("ERROR: tree result mismatch exp v%0d %0d-%0d w%0d t%0d n%0d c%0d l%0d",
                       want.valid, want.a, want.b, want.w, want.total, want.cnt,
                       want.complete, want.last,
                       "  got v%0d %0d-%0d w%0d t%0d n%0d c%0d l%0d",
                       got.valid, got.a, got.b, got.w, got.total, got.cnt,
                       got.complete, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= tree_q.size();
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

// Top of the spanning-tree testbench: drives edge requests and vertex-count
// writes, stalls the tree channel at random, and gives the verdict. All
// prediction and comparison lives in mst_checker.
module tb_top;
  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [5:0]         cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [4:0]         from_vertex;
  logic [4:0]         to_vertex;
  logic signed [15:0] edge_weight;
  logic               final_edge;
  logic               out_valid;
  logic               out_stall;
  logic               edge_valid;
  logic [4:0]         tree_from;
  logic [4:0]         tree_to;
  logic signed [15:0] tree_weight;
  logic signed [20:0] running_total;
  logic [4:0]         tree_edges;
  logic               tree_complete;
  logic               last_result;
  int                 fail_count;
  int                 pending;
  int                 results_seen;
  int                 graphs_seen;
  int                 requests_sent;
  logic [5:0]         vc_now;     // mirror of the register, used to aim endpoints

  minimum_spanning_tree_kruskal_core DUT (.*);
  mst_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit: far above what the worst graphs need.
  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end

  // Mostly short gaps, now and then a long one, sometimes none at all.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Tree channel back-pressure.
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      n = gap_len();
      out_stall <= (n != 0);
      repeat (n == 0 ? $urandom_range(1, 8) : n) @(posedge clk);
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // Send one edge request and hold it until taken; valid stays up into a
  // back-to-back request and drops only when a gap follows.
  task automatic send_edge(int a, int b, int w, bit fin);
    int n;
    n = gap_len();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid    <= 1'b1;
    from_vertex <= a[4:0];
    to_vertex   <= b[4:0];
    edge_weight <= w[15:0];
    final_edge  <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  // Register writes happen only with the block quiet: drain, then let the
  // run's tail settle before writing.
  task automatic drain_results();
    int i;
    in_valid <= 1'b0;
    i = 0;
    @(posedge clk);
    while ((pending != 0 || in_stall) && i < 2000000) begin
      @(posedge clk);
      i++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_vcount(logic [5:0] v);
    drain_results();
    cfg_write <= 1'b1;
    cfg_wdata <= v;
    vc_now = v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Random graph: mostly in-range endpoints, some out of range, some loops.
  task automatic random_graph(int n_edges, int wspan);
    int nv;
    int a;
    int b;
    nv = (vc_now == 0) ? 1 : (vc_now > 32 ? 32 : vc_now);
    for (int i = 0; i < n_edges; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        a = $urandom_range(0, 31);
        b = $urandom_range(0, 31);
      end else begin
        a = $urandom_range(0, nv - 1);
        b = $urandom_range(0, nv - 1);
      end
      send_edge(a, b, $urandom_range(0, 2 * wspan) - wspan, i == n_edges - 1);
    end
  endtask

  initial begin
    int gsize;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    from_vertex = '0;
    to_vertex = '0;
    edge_weight = '0;
    final_edge = 1'b0;
    requests_sent = 0;
    vc_now = 6'd32;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset vertex count, extremes, ties, loops, dropped edges.
    send_edge(0, 31, 32767, 0);
    send_edge(31, 0, -32768, 0);
    send_edge(5, 5, -100, 0);           // self loop
    send_edge(1, 2, 7, 0);
    send_edge(2, 3, 7, 0);              // tie keeps load order
    send_edge(1, 3, 7, 1);
    send_edge(3, 3, 0, 1);              // nothing accepted
    write_vcount(6'd4);
    send_edge(0, 9, 1, 0);              // endpoint out of range: dropped
    send_edge(0, 1, 3, 0);
    send_edge(1, 2, -3, 0);
    send_edge(2, 3, 21845, 0);
    send_edge(0, 3, -21846, 1);
    write_vcount(6'd1);                 // single vertex: empty tree complete
    send_edge(0, 0, 5, 1);
    write_vcount(6'd0);                 // acts as one vertex
    send_edge(0, 0, -1, 1);
    write_vcount(6'd63);                // clamps to 32
    send_edge(30, 31, 100, 0);
    send_edge(31, 30, 99, 1);
    write_vcount(6'd6);
    send_edge(0, 1, 1, 0);
    send_edge(2, 3, 2, 0);
    write_vcount(6'd2);                 // stored edges now partly out of range
    send_edge(0, 1, 5, 1);

    // Random graphs over several vertex counts; sender waits for the tree
    // each time a register write follows.
    while (requests_sent < 230) begin
      if ($urandom_range(0, 3) == 0)
        write_vcount($urandom_range(0, 9) == 0 ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(1, 32)));
      gsize = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      random_graph(gsize, ($urandom_range(0, 3) == 0) ? 32768 : 8);
    end
    // Overflow the store once to cover dropped edges at capacity.
    write_vcount(6'd32);
    for (int i = 0; i < 260; i++)
      send_edge($urandom_range(0, 31), $urandom_range(0, 31),
                $urandom_range(0, 65535) - 32768, i == 259);

    drain_results();
    $display("Covered %0d edge requests over %0d graphs, %0d tree results checked.",
             requests_sent, graphs_seen, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/mstk_pkg.sv
hdl/mstk_ctrl.sv
hdl/mstk_dp.sv
hdl/minimum_spanning_tree_kruskal_core.sv
verif/mst_checker.sv
verif/tb_top.sv
